### sv/bdee_pkg.sv
// Package: shared widths and constants of the byte delta entropy estimator.
`default_nettype none
package bdee_pkg;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned OUT_W     = 18;
	localparam int unsigned SUM_WIDTH = 19;
	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned POP_W     = $clog2(BYTE_W + 1);
	localparam int unsigned CMP_W     = (SUM_WIDTH > OUT_W) ? SUM_WIDTH : OUT_W;

	localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(5);
	localparam logic [COUNT_W-1:0] MIN_LEN   = COUNT_W'(4);
	localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [OUT_W-1:0]     result_t;
	typedef logic [SUM_WIDTH-1:0] sum_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [POP_W-1:0]     pop_t;

	function automatic pop_t popcount8(input byte_t v);
		pop_t n;
		n = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			n = n + pop_t'(v[k]);
		end
		return n;
	endfunction
endpackage
`default_nettype wire

### sv/bdee_in_if.sv
// Interface: input byte channel with valid/ready handshake.
`default_nettype none
interface bdee_in_if;
	import bdee_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_item;

	modport source (output valid, output data_byte, output last_item, input ready);
	modport sink   (input valid, input data_byte, input last_item, output ready);
endinterface
`default_nettype wire

### sv/bdee_out_if.sv
// Interface: result channel with valid/ready handshake.
`default_nettype none
interface bdee_out_if;
	import bdee_pkg::*;
	logic    valid;
	logic    ready;
	result_t entropy_bits;

	modport source (output valid, output entropy_bits, input ready);
	modport sink   (input valid, input entropy_bits, output ready);
endinterface
`default_nettype wire

### sv/byte_delta_entropy_estimator_core.sv
// Top level: byte delta entropy estimator core.
//
// Usage:
//   byte_in carries one buffer byte per beat (data_byte) and last_item on the
//   final byte of a buffer. Every byte is scored: the smallest of its first,
//   second and third XOR differences is found and its population count is
//   added to a saturating sum. The final byte produces one beat on result:
//   half the sum, or zero when the buffer held four bytes or fewer. Bytes
//   that are not final produce no beat.
//   Order: a byte is captured in the input register and scored from there;
//   a final byte waits for a free result register, then its result is loaded
//   there and shown on result. Throughput: one byte per cycle outside such a
//   wait, set by the single input register feeding the score logic and the
//   single result register.
//   Stall: while result is held by the receiver, bytes that are not final
//   keep flowing; a final byte waits in the input register until the result
//   register frees up, and byte_in.ready drops only in that case.
//   Reset: arst_n clears the valid flags, the difference history, the sum
//   and the byte count; the first byte after reset starts a new buffer.
`default_nettype none
module byte_delta_entropy_estimator_core (
	input  wire            clk,
	input  wire            arst_n,
	bdee_in_if.sink        byte_in,
	bdee_out_if.source     result
);
	import bdee_pkg::*;

	// input register
	logic    valid_s1;
	byte_t   data_s1;
	logic    last_s1;

	// per-buffer history
	byte_t   prev_byte_q;
	byte_t   prev_delta_q;
	byte_t   prev_delta_two_q;
	sum_t    sum_q;
	count_t  count_q;

	// result register
	logic    out_valid_q;
	result_t out_data_q;

	logic    out_free;
	logic    advance;
	logic    in_fire;
	byte_t   d1, d2, d3, dmin;
	logic    [SUM_WIDTH:0] sum_ext;
	sum_t    sum_next;
	count_t  count_next;
	sum_t    half;
	logic    [CMP_W-1:0] half_ext;
	result_t estimate;

	// Result register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || result.ready;
	// Score the held byte unless it is final and the result register is full.
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign byte_in.ready = !valid_s1 || advance;
	assign in_fire  = byte_in.valid && byte_in.ready;

	// Differences against history, smallest of the three, and its weight.
	always_comb begin
		d1 = prev_byte_q ^ data_s1;
		d2 = d1 ^ prev_delta_q;
		d3 = d2 ^ prev_delta_two_q;
		dmin = d1;
		if (dmin > d2) begin
			dmin = d2;
		end
		if (dmin > d3) begin
			dmin = d3;
		end
		sum_ext  = {1'b0, sum_q} + (SUM_WIDTH + 1)'(popcount8(dmin));
		// saturate at the top of the sum range
		sum_next = sum_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_ext[SUM_WIDTH-1:0];
		count_next = (count_q < COUNT_SAT) ? count_q + count_t'(1) : count_q;
		half     = sum_next >> 1;
		half_ext = CMP_W'(half);
		if (count_next <= MIN_LEN) begin
			estimate = '0;
		end else if (half_ext > CMP_W'(OUT_MAX)) begin
			estimate = OUT_MAX;
		end else begin
			estimate = OUT_W'(half_ext);
		end
	end

	// Input register: load on every accepted beat, drop valid once scored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_item;
		end
	end

	// History: advance per scored byte, clear after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q      <= '0;
			prev_delta_q     <= '0;
			prev_delta_two_q <= '0;
			sum_q            <= '0;
			count_q          <= '0;
		end else if (advance) begin
			if (last_s1) begin
				prev_byte_q      <= '0;
				prev_delta_q     <= '0;
				prev_delta_two_q <= '0;
				sum_q            <= '0;
				count_q          <= '0;
			end else begin
				prev_byte_q      <= data_s1;
				prev_delta_q     <= d1;
				prev_delta_two_q <= d2;
				sum_q            <= sum_next;
				count_q          <= count_next;
			end
		end
	end

	// Result register: load on a final byte, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= estimate;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.entropy_bits = out_data_q;
endmodule
`default_nettype wire

### sv/bdee_checker.sv
// Checker: port-level assertions for the estimator core, and its bind.
`default_nettype none
module bdee_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  in_last,
	input wire                  out_valid,
	input wire                  out_ready,
	input bdee_pkg::result_t    entropy_bits
);
	import bdee_pkg::*;

	// final beats accepted whose results are not yet delivered
	logic [1:0] pending_q;
	logic       last_fire;
	logic       out_fire;

	assign last_fire = in_valid && in_ready && in_last;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_fire && !out_fire) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_fire && !last_fire) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entropy_bits))
		else $error("result beat changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> !out_valid)
		else $error("result beat without a final input beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more final beats in flight than storage allows");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while result side is free");
endmodule

bind byte_delta_entropy_estimator_core bdee_checker u_bdee_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_in.valid),
	.in_ready     (byte_in.ready),
	.in_last      (byte_in.last_item),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.entropy_bits (result.entropy_bits)
);
`default_nettype wire
